// ===== rtl/clipped_palette_keyed_blitter_assert.svh =====
// Assertion macros shared by the blitter RTL.
`ifndef CLIPPED_PALETTE_KEYED_BLITTER_ASSERT_SVH
`define CLIPPED_PALETTE_KEYED_BLITTER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, quiet while reset is held.
`define CPKB_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, quiet while reset is held.
`define CPKB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cpkb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cpkb_pkg;

    // Framebuffer geometry
    localparam logic [12:0] FB_WIDTH  = 13'd320;
    localparam logic [12:0] FB_HEIGHT = 13'd200;

    // Palette
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int COLOUR_W      = 32;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SOURCE_WIDTH = 3'd0,
        REG_SUB_X        = 3'd1,
        REG_SUB_Y        = 3'd2,
        REG_SUB_WIDTH    = 3'd3,
        REG_SUB_HEIGHT   = 3'd4,
        REG_DEST_X       = 3'd5,
        REG_DEST_Y       = 3'd6,
        REG_BLIT_CONTROL = 3'd7
    } t_reg_index;

    // Input item kinds
    localparam logic CMD_PIXEL     = 1'b0;
    localparam logic CMD_PAL_WRITE = 1'b1;

    // Grayscale ramp held by a palette entry until first written
    function automatic logic [COLOUR_W-1:0] pal_reset_entry(input logic [PAL_AW-1:0] idx);
        pal_reset_entry = {8'hFF, idx, idx, idx};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cpkb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cpkb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Hold read data between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/clipped_palette_keyed_blitter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Clipped, colour-keyed palette blitter. Source pixels arrive in raster order
// on the slave stream, with the kind in tuser (0 pixel, 1 palette entry write)
// and tlast on the final pixel of a blit, which returns the column and row
// counters to zero. Every input transaction yields exactly one output
// transaction: a framebuffer write request whose enable is set only when the
// pixel lies inside the source subrectangle, its destination lands inside the
// framebuffer and, in palette mode with masking on, its index differs from the
// key. Disabled requests carry zero address and colour; palette writes produce
// an all-zero request. The block takes one transaction per clock cycle while
// the output is not stalled. The clip test, address multiply and palette RAM
// read fill stage 1, which feeds the output register. The palette sits
// in a single-port-read RAM; per-entry valid flags make unwritten entries read
// as the grayscale ramp straight out of reset, so no clearing pass is needed.
// Configuration writes take effect at once and are meant for idle periods.

module clipped_palette_keyed_blitter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data,
    // Source stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,   // [31:0] pixel, [39:32] pal_index
    input  wire logic [0:0]  i_s_axis_tuser,   // [0] cmd
    input  wire logic        i_s_axis_tlast,   // last
    // Framebuffer write request stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [55:0] o_m_axis_tdata,   // [0] write_enable, [16:1] fb_address,
                                               // [48:17] colour, [55:49] zero
    output logic             o_m_axis_tlast    // done_res
);

    localparam int AW = cpkb_pkg::PAL_AW;
    localparam int CW = cpkb_pkg::COLOUR_W;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [12:0] r_source_width;
    logic [12:0] r_sub_x;
    logic [12:0] r_sub_y;
    logic [12:0] r_sub_width;
    logic [12:0] r_sub_height;
    logic [12:0] r_dest_x;
    logic [12:0] r_dest_y;
    logic [9:0]  r_blit_control;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_width <= 13'd320;
            r_sub_x        <= '0;
            r_sub_y        <= '0;
            r_sub_width    <= 13'd4096;
            r_sub_height   <= 13'd4096;
            r_dest_x       <= '0;
            r_dest_y       <= '0;
            r_blit_control <= '0;
        end else if (i_cfg_we) begin
            case (cpkb_pkg::t_reg_index'(i_cfg_index))
                cpkb_pkg::REG_SOURCE_WIDTH: r_source_width <= i_cfg_data;
                cpkb_pkg::REG_SUB_X:        r_sub_x        <= i_cfg_data;
                cpkb_pkg::REG_SUB_Y:        r_sub_y        <= i_cfg_data;
                cpkb_pkg::REG_SUB_WIDTH:    r_sub_width    <= i_cfg_data;
                cpkb_pkg::REG_SUB_HEIGHT:   r_sub_height   <= i_cfg_data;
                cpkb_pkg::REG_DEST_X:       r_dest_x       <= i_cfg_data;
                cpkb_pkg::REG_DEST_Y:       r_dest_y       <= i_cfg_data;
                cpkb_pkg::REG_BLIT_CONTROL: r_blit_control <= i_cfg_data[9:0];
                default:                    ;
            endcase
        end
    end

    logic [7:0] w_key;
    logic       w_pal_mode;
    logic       w_mask_en;
    assign w_key      = r_blit_control[7:0];
    assign w_pal_mode = r_blit_control[8];
    assign w_mask_en  = r_blit_control[9];

    // ---------------------------------------------------------------
    // Input unpacking and flow control
    // ---------------------------------------------------------------
    logic [31:0]   w_pixel;
    logic [AW-1:0] w_pal_index;
    logic          w_cmd;
    logic          w_last;
    assign w_pixel     = i_s_axis_tdata[31:0];
    assign w_pal_index = i_s_axis_tdata[39:32];
    assign w_cmd       = i_s_axis_tuser[0];
    assign w_last      = i_s_axis_tlast;

    logic r_s1_valid;
    logic r_out_valid;
    logic w_out_adv;
    logic w_accept;
    logic w_pix_accept;
    logic w_pal_write;

    // Output register frees when empty or taken; stage 1 frees when it moves on
    assign w_out_adv       = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || w_out_adv;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_pix_accept    = w_accept && (w_cmd == cpkb_pkg::CMD_PIXEL);
    assign w_pal_write     = w_accept && (w_cmd == cpkb_pkg::CMD_PAL_WRITE);

    // ---------------------------------------------------------------
    // Position counters
    // ---------------------------------------------------------------
    logic [11:0] r_src_col, n_src_col;
    logic [11:0] r_src_row, n_src_row;
    logic        w_col_wrap;

    assign w_col_wrap = ({1'b0, r_src_col} + 13'd1 >= r_source_width) || (r_src_col == 12'hFFF);

    always_comb begin
        n_src_col = r_src_col;
        n_src_row = r_src_row;
        if (w_last) begin
            n_src_col = '0;
            n_src_row = '0;
        end else if (w_col_wrap) begin
            n_src_col = '0;
            if (r_src_row != 12'hFFF) begin
                n_src_row = r_src_row + 12'd1;
            end
        end else begin
            n_src_col = r_src_col + 12'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col <= '0;
            r_src_row <= '0;
        end else if (w_pix_accept) begin
            r_src_col <= n_src_col;
            r_src_row <= n_src_row;
        end
    end

    // ---------------------------------------------------------------
    // Clip test and address (accept cycle)
    // ---------------------------------------------------------------
    logic signed [15:0] w_rel_c, w_rel_r;
    logic signed [15:0] w_dx, w_dy;
    logic               w_inside;
    logic               w_dest_ok;
    logic               w_key_hit;
    logic               w_en;
    logic [24:0]        w_row_base;
    logic [15:0]        w_addr;

    assign w_rel_c = signed'({4'b0, r_src_col}) - signed'({{3{r_sub_x[12]}}, r_sub_x});
    assign w_rel_r = signed'({4'b0, r_src_row}) - signed'({{3{r_sub_y[12]}}, r_sub_y});
    assign w_dx    = signed'({{3{r_dest_x[12]}}, r_dest_x}) + w_rel_c;
    assign w_dy    = signed'({{3{r_dest_y[12]}}, r_dest_y}) + w_rel_r;

    // A non-negative offset below the subrectangle size lies inside it
    assign w_inside  = !w_rel_c[15] && (w_rel_c[14:0] < {2'b0, r_sub_width}) &&
                       !w_rel_r[15] && (w_rel_r[14:0] < {2'b0, r_sub_height});
    assign w_dest_ok = !w_dx[15] && (w_dx[14:0] < {2'b0, cpkb_pkg::FB_WIDTH}) &&
                       !w_dy[15] && (w_dy[14:0] < {2'b0, cpkb_pkg::FB_HEIGHT});
    // Keying applies to palette mode only
    assign w_key_hit = w_pal_mode && w_mask_en && (w_pixel[7:0] == w_key);
    assign w_en      = w_inside && w_dest_ok && !w_key_hit;

    // An enabled destination is below 4096 in both axes
    assign w_row_base = w_dy[11:0] * cpkb_pkg::FB_WIDTH;
    assign w_addr     = w_row_base[15:0] + {4'b0, w_dx[11:0]};

    // ---------------------------------------------------------------
    // Palette RAM and valid flags
    // ---------------------------------------------------------------
    localparam int PALETTE_FLAGS_W = cpkb_pkg::PALETTE_DEPTH;
    logic [PALETTE_FLAGS_W-1:0] r_pal_valid;
    logic [CW-1:0] w_ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_valid <= '0;
        end else if (w_pal_write) begin
            r_pal_valid[w_pal_index] <= 1'b1;
        end
    end

    // A write lands in the RAM before any later read is taken, so no forwarding is needed
    cpkb_ram #(
        .WIDTH (CW),
        .DEPTH (cpkb_pkg::PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_pal_write),
        .i_waddr (w_pal_index),
        .i_wdata (w_pixel),
        .i_re    (w_pix_accept),
        .i_raddr (w_pixel[AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // ---------------------------------------------------------------
    // Stage 1: palette read in flight
    // ---------------------------------------------------------------
    logic          r_s1_en;
    logic [15:0]   r_s1_addr;
    logic [31:0]   r_s1_pixel;
    logic          r_s1_pal_mode;
    logic          r_s1_pal_valid;
    logic          r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            // Palette writes report nothing
            r_s1_en        <= w_en && (w_cmd == cpkb_pkg::CMD_PIXEL);
            r_s1_addr      <= w_addr;
            r_s1_pixel     <= w_pixel;
            r_s1_pal_mode  <= w_pal_mode;
            r_s1_pal_valid <= r_pal_valid[w_pixel[AW-1:0]];
            r_s1_last      <= w_last && (w_cmd == cpkb_pkg::CMD_PIXEL);
        end
    end

    logic [CW-1:0] w_s1_pal_colour;
    logic [CW-1:0] w_s1_colour;

    // Unwritten entries show the reset ramp
    assign w_s1_pal_colour = r_s1_pal_valid ? w_ram_rdata
                                            : cpkb_pkg::pal_reset_entry(r_s1_pixel[AW-1:0]);
    assign w_s1_colour     = !r_s1_en      ? '0 :
                             r_s1_pal_mode ? w_s1_pal_colour : r_s1_pixel;

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic        r_out_we;
    logic [15:0] r_out_addr;
    logic [31:0] r_out_colour;
    logic        r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv && r_s1_valid) begin
            r_out_we     <= r_s1_en;
            r_out_addr   <= r_s1_en ? r_s1_addr : 16'd0;
            r_out_colour <= w_s1_colour;
            r_out_last   <= r_s1_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_colour, r_out_addr, r_out_we};
    assign o_m_axis_tlast  = r_out_last;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `include "clipped_palette_keyed_blitter_assert.svh"

    `CPKB_ASSERT(a_disabled_is_zero, r_out_valid && !r_out_we, (r_out_addr == 16'd0) && (r_out_colour == 32'd0), "disabled write carries data")
    `CPKB_ASSERT(a_stall_blocks_input, r_s1_valid && r_out_valid && !i_m_axis_tready, !o_s_axis_tready, "input taken while pipeline full")
    `CPKB_ASSERT_NEXT(a_last_clears_pos, w_pix_accept && w_last, (r_src_col == 12'd0) && (r_src_row == 12'd0), "counters not cleared after last")

endmodule

`default_nettype wire

// ===== bench/clipped_palette_keyed_blitter_tb.sv =====
`timescale 1ns / 1ps

module clipped_palette_keyed_blitter_tb;

    // blit_control bit positions
    localparam int CTRL_PAL_BIT  = 8;
    localparam int CTRL_MASK_BIT = 9;
    // Position counters are 12 bits wide
    localparam int POS_MAX       = 4095;
    // Give up long after the slowest legal run would have ended
    localparam int LIMIT_NS      = 40_000_000;
    // Item kinds, short names for the directed table
    localparam logic ITEM_PIX    = cpkb_pkg::CMD_PIXEL;
    localparam logic ITEM_PAL    = cpkb_pkg::CMD_PAL_WRITE;

    // One framebuffer write request, as it leaves the block
    typedef struct packed {
        logic        we;
        logic [15:0] addr;
        logic [31:0] colour;
        logic        done;
    } t_fb_req;

    // One line of the directed sequence: a register write or a stream transaction
    typedef struct packed {
        logic                 is_cfg;
        cpkb_pkg::t_reg_index reg_idx;
        logic [12:0]          reg_val;
        logic                 cmd;
        logic [31:0]          pix;
        logic [7:0]           pal_idx;
        logic                 last;
        logic                 typed;
        t_fb_req              want;
    } t_plan_row;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    cpkb_pkg::t_reg_index cfg_index = cpkb_pkg::REG_SOURCE_WIDTH;
    logic [12:0]          cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic [39:0]          s_data    = '0;
    logic [0:0]           s_user    = '0;
    logic                 s_last    = 1'b0;
    logic                 m_ready   = 1'b0;
    wire                  s_ready;
    wire                  m_valid;
    wire  [55:0]          m_data;
    wire                  m_last;

    // Shadow copy of the block's registers and state, kept by the predictor
    logic [12:0] shadow_src_width, shadow_sub_x, shadow_sub_y, shadow_sub_w, shadow_sub_h;
    logic [12:0] shadow_dest_x, shadow_dest_y;
    logic [9:0]  shadow_ctrl;
    logic [11:0] col_cnt, row_cnt;
    logic [31:0] palette_copy [256];

    // Requests still owed by the block, oldest first
    t_fb_req     pending_writes [$];
    int          n_fail = 0;
    // Random idling on both sides; cleared for the closing stretch
    bit          bursty = 1'b1;

    clipped_palette_keyed_blitter u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),     // [31:0] pixel, [39:32] pal_index
        .i_s_axis_tuser  (s_user),     // [0] cmd
        .i_s_axis_tlast  (s_last),     // last
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),     // [0] write_enable, [16:1] fb_address, [48:17] colour
        .o_m_axis_tlast  (m_last)      // done_res
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #LIMIT_NS;
        $display("Test completed with failures");
        $finish;
    end

    // Work out the request for one accepted transaction and advance the shadow state.
    function automatic t_fb_req blit_step(input logic cmd, input logic [31:0] pix,
                                          input logic [7:0] pal_idx, input logic last);
        t_fb_req r;
        int      col, row, sx, sy, dx, dy;
        logic    en;
        r = '0;
        // Palette write: store the entry, answer with an all-zero request, keep position
        if (cmd == cpkb_pkg::CMD_PAL_WRITE) begin
            palette_copy[pal_idx] = pix;
            return r;
        end
        col = int'(col_cnt);
        row = int'(row_cnt);
        sx  = int'($signed(shadow_sub_x));
        sy  = int'($signed(shadow_sub_y));
        dx  = int'($signed(shadow_dest_x)) + (col - sx);
        dy  = int'($signed(shadow_dest_y)) + (row - sy);
        // Inside the subrectangle and landing inside the framebuffer
        en  = col >= sx && col < sx + int'(shadow_sub_w) &&
              row >= sy && row < sy + int'(shadow_sub_h) &&
              dx >= 0 && dx < int'(cpkb_pkg::FB_WIDTH) &&
              dy >= 0 && dy < int'(cpkb_pkg::FB_HEIGHT);
        // Keying only applies to palette indexes, never to direct ARGB
        if (shadow_ctrl[CTRL_PAL_BIT]) begin
            r.colour = palette_copy[pix[7:0]];
            if (shadow_ctrl[CTRL_MASK_BIT] && pix[7:0] == shadow_ctrl[7:0])
                en = 1'b0;
        end else begin
            r.colour = pix;
        end
        if (en) begin
            r.we   = 1'b1;
            r.addr = 16'(dy * int'(cpkb_pkg::FB_WIDTH) + dx);
        end else begin
            r.colour = '0;
        end
        r.done = last;
        // Advance the raster position: wrap the column, saturate the row
        if (last) begin
            col_cnt = '0;
            row_cnt = '0;
        end else if (col + 1 >= int'(shadow_src_width) || col >= POS_MAX) begin
            col_cnt = '0;
            if (row < POS_MAX)
                row_cnt = row_cnt + 12'd1;
        end else begin
            col_cnt = col_cnt + 12'd1;
        end
        return r;
    endfunction

    function automatic t_plan_row cfg_row(input cpkb_pkg::t_reg_index idx,
                                          input logic [12:0] val);
        t_plan_row r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // typed set: the request is taken from the row, not from the predictor
    function automatic t_plan_row item_row(input logic cmd, input logic [31:0] pix,
                                           input logic [7:0] pal_idx, input logic last,
                                           input logic typed, input logic we,
                                           input logic [15:0] addr, input logic [31:0] colour);
        t_plan_row r;
        r             = '0;
        r.cmd         = cmd;
        r.pix         = pix;
        r.pal_idx     = pal_idx;
        r.last        = last;
        r.typed       = typed;
        r.want.we     = we;
        r.want.addr   = addr;
        r.want.colour = colour;
        r.want.done   = (cmd == cpkb_pkg::CMD_PIXEL) ? last : 1'b0;
        return r;
    endfunction

    function automatic int pick_coord(input int rim, input int lo, input int hi);
        case ($urandom_range(0, 9))
            0:       return -4096;
            1:       return 4095;
            2:       return rim;
            default: return lo + int'($urandom_range(0, hi - lo));
        endcase
    endfunction

    function automatic int pick_size();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 4096;
            2:       return int'($urandom_range(1, 4096));
            default: return int'($urandom_range(1, 48));
        endcase
    endfunction

    // Hold the write for one edge, then drop the enable before returning.
    task automatic write_reg(input cpkb_pkg::t_reg_index idx, input logic [12:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            cpkb_pkg::REG_SOURCE_WIDTH: shadow_src_width = val;
            cpkb_pkg::REG_SUB_X:        shadow_sub_x     = val;
            cpkb_pkg::REG_SUB_Y:        shadow_sub_y     = val;
            cpkb_pkg::REG_SUB_WIDTH:    shadow_sub_w     = val;
            cpkb_pkg::REG_SUB_HEIGHT:   shadow_sub_h     = val;
            cpkb_pkg::REG_DEST_X:       shadow_dest_x    = val;
            cpkb_pkg::REG_DEST_Y:       shadow_dest_y    = val;
            cpkb_pkg::REG_BLIT_CONTROL: shadow_ctrl      = val[9:0];
            default: ;
        endcase
    endtask

    // Offer one transaction, wait for the handshake, then log what the block owes.
    task automatic send_item(input logic cmd, input logic [31:0] pix, input logic [7:0] pal_idx,
                             input logic last, input logic typed, input t_fb_req want);
        t_fb_req predicted;
        if (bursty && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {pal_idx, pix};
        s_user  <= cmd;
        s_last  <= last;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        predicted = blit_step(cmd, pix, pal_idx, last);
        pending_writes.push_back(typed ? want : predicted);
    endtask

    // Stop offering and hold until every owed request has come out.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge clk);
    endtask

    task automatic random_setup();
        int sw;
        case ($urandom_range(0, 9))
            0:          sw = 1;
            1:          sw = 4096;
            2, 3, 4, 5: sw = int'($urandom_range(2, 40));
            default:    sw = int'($urandom_range(41, 400));
        endcase
        write_reg(cpkb_pkg::REG_SOURCE_WIDTH, 13'(sw));
        write_reg(cpkb_pkg::REG_SUB_X,        13'(pick_coord(0, -8, 24)));
        write_reg(cpkb_pkg::REG_SUB_Y,        13'(pick_coord(0, -8, 24)));
        write_reg(cpkb_pkg::REG_SUB_WIDTH,    13'(pick_size()));
        write_reg(cpkb_pkg::REG_SUB_HEIGHT,   13'(pick_size()));
        write_reg(cpkb_pkg::REG_DEST_X,       13'(pick_coord(319, -20, 340)));
        write_reg(cpkb_pkg::REG_DEST_Y,       13'(pick_coord(199, -20, 220)));
        write_reg(cpkb_pkg::REG_BLIT_CONTROL, 13'($urandom_range(0, 1023)));
    endtask

    // Mostly whole blits closed by last, with palette updates and the odd stray last mixed in.
    task automatic random_burst(input int n);
        int          frame_left;
        int          pause_at;
        logic        cmd;
        logic [31:0] pix;
        logic [7:0]  pal_idx;
        logic        last;
        frame_left = int'($urandom_range(1, 150));
        pause_at   = int'($urandom_range(0, n - 1));
        for (int k = 0; k < n; k++) begin
            pix     = $urandom;
            pal_idx = 8'($urandom_range(0, 255));
            last    = 1'b0;
            if ($urandom_range(0, 99) < 8) begin
                cmd  = cpkb_pkg::CMD_PAL_WRITE;
                last = 1'($urandom_range(0, 1));
            end else begin
                cmd = cpkb_pkg::CMD_PIXEL;
                // Hit the key often whenever keying could matter
                if ((shadow_ctrl[CTRL_PAL_BIT] || shadow_ctrl[CTRL_MASK_BIT]) &&
                    $urandom_range(0, 3) == 0)
                    pix[7:0] = shadow_ctrl[7:0];
                frame_left--;
                if (frame_left == 0 || $urandom_range(0, 99) == 0) begin
                    last       = 1'b1;
                    frame_left = int'($urandom_range(1, 150));
                end
            end
            send_item(cmd, pix, pal_idx, last, 1'b0, '0);
            // Hold the sender once until the block has caught up
            if (k == pause_at)
                drain();
        end
    endtask

    // Receiver: ready in stretches, stalls in bursts while idling is on
    initial begin
        @(posedge clk);
        forever begin
            if (bursty && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
            n_fail++;
        end
    endfunction

    // Compare every request the receiver takes with the oldest one owed
    always @(posedge clk) begin : req_monitor
        t_fb_req got;
        t_fb_req want;
        if (rst_n && m_valid && m_ready) begin
            got = {m_data[0], m_data[16:1], m_data[48:17], m_last};
            if (pending_writes.size() == 0) begin
                $display("%0t: request with none owed, expected nothing, got %h", $time, got);
                n_fail++;
            end else begin
                want = pending_writes.pop_front();
                check_field("write_enable", 32'(want.we),   32'(got.we));
                check_field("fb_address",   32'(want.addr), 32'(got.addr));
                check_field("colour",       want.colour,    got.colour);
                check_field("done",         32'(want.done), 32'(got.done));
            end
        end
    end

    initial begin
        t_plan_row plan [$];

        // Shadow state out of reset: grayscale palette, full-size subrectangle
        shadow_src_width = 13'd320;
        shadow_sub_x     = '0;
        shadow_sub_y     = '0;
        shadow_sub_w     = 13'd4096;
        shadow_sub_h     = 13'd4096;
        shadow_dest_x    = '0;
        shadow_dest_y    = '0;
        shadow_ctrl      = '0;
        col_cnt          = '0;
        row_cnt          = '0;
        for (int i = 0; i < 256; i++)
            palette_copy[i] = 32'hFF00_0000 | (i * 32'h0001_0101);

        // Reset values: direct ARGB straight to the top-left of the framebuffer
        plan.push_back(item_row(ITEM_PIX, 32'hFFFF_FFFF, 8'h00, 1'b0,
                                1'b1, 1'b1, 16'd0, 32'hFFFF_FFFF));
        plan.push_back(item_row(ITEM_PIX, 32'h0000_0000, 8'hFF, 1'b0,
                                1'b1, 1'b1, 16'd1, 32'h0));
        // Palette write mid-row: zero request, last ignored, position kept
        plan.push_back(item_row(ITEM_PAL, 32'hDEAD_BEEF, 8'hFF, 1'b1,
                                1'b1, 1'b0, 16'd0, 32'h0));
        plan.push_back(item_row(ITEM_PIX, 32'h8000_0001, 8'h00, 1'b1,
                                1'b1, 1'b1, 16'd2, 32'h8000_0001));
        // Palette mode: written entry, then untouched ramp entries
        plan.push_back(cfg_row(cpkb_pkg::REG_BLIT_CONTROL, 13'h100));
        plan.push_back(item_row(ITEM_PIX, 32'h0000_00FF, 8'h00, 1'b0,
                                1'b1, 1'b1, 16'd0, 32'hDEAD_BEEF));
        plan.push_back(item_row(ITEM_PIX, 32'hFFFF_FF00, 8'h00, 1'b0,
                                1'b1, 1'b1, 16'd1, 32'hFF00_0000));
        plan.push_back(item_row(ITEM_PIX, 32'h1234_5680, 8'h00, 1'b0,
                                1'b1, 1'b1, 16'd2, 32'hFF80_8080));
        // Masking on with key 0xFF: keyed index dropped, neighbour passes
        plan.push_back(cfg_row(cpkb_pkg::REG_BLIT_CONTROL, 13'h3FF));
        plan.push_back(item_row(ITEM_PIX, 32'h0000_00FF, 8'h00, 1'b0,
                                1'b1, 1'b0, 16'd0, 32'h0));
        plan.push_back(item_row(ITEM_PIX, 32'h0000_00FE, 8'h00, 1'b1,
                                1'b1, 1'b1, 16'd4, 32'hFFFE_FEFE));
        // Mask without palette mode: direct pixel equal to the key still written
        plan.push_back(cfg_row(cpkb_pkg::REG_BLIT_CONTROL, 13'h2FF));
        plan.push_back(item_row(ITEM_PIX, 32'h0000_00FF, 8'h00, 1'b1,
                                1'b1, 1'b1, 16'd0, 32'h0000_00FF));
        // Corners at the far ends of the signed range: nothing lands
        plan.push_back(cfg_row(cpkb_pkg::REG_SOURCE_WIDTH, 13'd1));
        plan.push_back(cfg_row(cpkb_pkg::REG_SUB_X, 13'h1000));
        plan.push_back(cfg_row(cpkb_pkg::REG_SUB_Y, 13'h1000));
        plan.push_back(cfg_row(cpkb_pkg::REG_DEST_X, 13'h0FFF));
        plan.push_back(cfg_row(cpkb_pkg::REG_DEST_Y, 13'h0FFF));
        plan.push_back(cfg_row(cpkb_pkg::REG_BLIT_CONTROL, 13'h000));
        plan.push_back(item_row(ITEM_PIX, 32'h55AA_55AA, 8'h00, 1'b0,
                                1'b1, 1'b0, 16'd0, 32'h0));
        plan.push_back(item_row(ITEM_PIX, 32'hAA55_AA55, 8'h00, 1'b1,
                                1'b0, 1'b0, 16'd0, 32'h0));
        // Empty subrectangle, first by width, then by height
        plan.push_back(cfg_row(cpkb_pkg::REG_SUB_WIDTH, 13'd0));
        plan.push_back(cfg_row(cpkb_pkg::REG_SUB_X, 13'd0));
        plan.push_back(cfg_row(cpkb_pkg::REG_SUB_Y, 13'd0));
        plan.push_back(cfg_row(cpkb_pkg::REG_DEST_X, 13'd0));
        plan.push_back(cfg_row(cpkb_pkg::REG_DEST_Y, 13'd0));
        plan.push_back(item_row(ITEM_PIX, 32'h1357_9BDF, 8'h00, 1'b1,
                                1'b1, 1'b0, 16'd0, 32'h0));
        plan.push_back(cfg_row(cpkb_pkg::REG_SUB_WIDTH, 13'd4096));
        plan.push_back(cfg_row(cpkb_pkg::REG_SUB_HEIGHT, 13'd0));
        plan.push_back(item_row(ITEM_PIX, 32'h2468_ACE0, 8'h00, 1'b1,
                                1'b1, 1'b0, 16'd0, 32'h0));
        // Bottom-right framebuffer pixel, then one step past it each way
        plan.push_back(cfg_row(cpkb_pkg::REG_SUB_HEIGHT, 13'd4096));
        plan.push_back(cfg_row(cpkb_pkg::REG_SOURCE_WIDTH, 13'd2));
        plan.push_back(cfg_row(cpkb_pkg::REG_DEST_X, 13'd319));
        plan.push_back(cfg_row(cpkb_pkg::REG_DEST_Y, 13'd199));
        plan.push_back(item_row(ITEM_PIX, 32'h0123_4567, 8'h00, 1'b0,
                                1'b1, 1'b1, 16'hF9FF, 32'h0123_4567));
        plan.push_back(item_row(ITEM_PIX, 32'h89AB_CDEF, 8'h00, 1'b0,
                                1'b1, 1'b0, 16'd0, 32'h0));
        plan.push_back(item_row(ITEM_PIX, 32'hFEDC_BA98, 8'h00, 1'b1,
                                1'b1, 1'b0, 16'd0, 32'h0));
        // One column left of the framebuffer, then its first column
        plan.push_back(cfg_row(cpkb_pkg::REG_DEST_X, 13'h1FFF));
        plan.push_back(cfg_row(cpkb_pkg::REG_DEST_Y, 13'd0));
        plan.push_back(item_row(ITEM_PIX, 32'h7FFF_FFFF, 8'h00, 1'b0,
                                1'b1, 1'b0, 16'd0, 32'h0));
        plan.push_back(item_row(ITEM_PIX, 32'h0000_0001, 8'h00, 1'b1,
                                1'b1, 1'b1, 16'd0, 32'h0000_0001));
        // Overwrite entry 0 and read it back through palette mode
        plan.push_back(cfg_row(cpkb_pkg::REG_SOURCE_WIDTH, 13'd4096));
        plan.push_back(item_row(ITEM_PAL, 32'h00C0_FFEE, 8'h00, 1'b0,
                                1'b1, 1'b0, 16'd0, 32'h0));
        plan.push_back(cfg_row(cpkb_pkg::REG_DEST_X, 13'd0));
        plan.push_back(cfg_row(cpkb_pkg::REG_BLIT_CONTROL, 13'h100));
        plan.push_back(item_row(ITEM_PIX, 32'hFFFF_FF00, 8'h00, 1'b1,
                                1'b1, 1'b1, 16'd0, 32'h00C0_FFEE));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sequence; registers only change once the block has gone quiet
        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                drain();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_item(plan[i].cmd, plan[i].pix, plan[i].pal_idx, plan[i].last,
                          plan[i].typed, plan[i].want);
            end
        end

        // Random settings, some phases with idling and some without
        for (int p = 0; p < 9; p++) begin
            drain();
            random_setup();
            bursty = ($urandom_range(0, 3) != 0);
            random_burst(int'($urandom_range(60, 80)));
        end

        // Closing stretch with both sides running flat out
        drain();
        random_setup();
        bursty = 1'b0;
        random_burst(60);

        // Let anything stray come out before judging
        drain();
        repeat (8) @(posedge clk);
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== clipped_palette_keyed_blitter.f =====
+incdir+rtl
rtl/cpkb_pkg.sv
rtl/cpkb_ram.sv
rtl/clipped_palette_keyed_blitter.sv
bench/clipped_palette_keyed_blitter_tb.sv
